### src/first_fit_heap_allocator_defines.svh
// assertion macros for the top-level allocator file
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define FFHA_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffha assertion failed");
// next-cycle implication
`define FFHA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffha assertion failed");
`else
`define FFHA_ASSERT(label, ante, cons)
`define FFHA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/ffha_pkg.sv
package ffha_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 16;
	localparam int ADDR_W       = 24;
	localparam int IDX_W        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
	localparam int TOP_W        = ADDR_W + 2;
	localparam int ENTRY_W      = 2 * ADDR_W;

	localparam logic [ADDR_W-1:0] LIMIT_RESET = ADDR_W'(1048576);

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_REUSED     = 3'd0,
		ST_EXTENDED   = 3'd1,
		ST_ZERO       = 3'd2,
		ST_HEAP_FULL  = 3'd3,
		ST_TABLE_FULL = 3'd4,
		ST_MARKED     = 3'd5,
		ST_RELEASED   = 3'd6,
		ST_UNKNOWN    = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic trivial;
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

### src/ffha_intf.sv
interface ffha_req_if;
	import ffha_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [ADDR_W-1:0] req_size;
	logic [ADDR_W-1:0] free_addr;

	modport source (output valid, req_type, req_size, free_addr, input ready);
	modport sink (input valid, req_type, req_size, free_addr, output ready);
endinterface

interface ffha_rsp_if;
	import ffha_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] result_addr;
	logic [2:0]        status;

	modport source (output valid, result_addr, status, input ready);
	modport sink (input valid, result_addr, status, output ready);
endinterface

### src/ffha_ram.sv
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/ffha_ctrl.sv
module ffha_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ffha_pkg::sts_t sts,
	output ffha_pkg::cmd_t cmd
);
	import ffha_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				// zero size or null pointer skips the walk
				if (sts.trivial || sts.scan_done) begin
					state_d = S_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/ffha_dp.sv
module ffha_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ffha_pkg::cmd_t              cmd,
	output ffha_pkg::sts_t              sts,
	input  logic                        cfg_we,
	input  logic [ffha_pkg::ADDR_W-1:0] cfg_wdata,
	input  logic                        req_type,
	input  logic [ffha_pkg::ADDR_W-1:0] req_size,
	input  logic [ffha_pkg::ADDR_W-1:0] free_addr,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ffha_pkg::ADDR_W-1:0] result_addr,
	output logic [2:0]                  status
);
	import ffha_pkg::*;

	localparam logic [ADDR_W-1:0] HDR = ADDR_W'(HEADER_BYTES);

	// control state
	logic [ADDR_W-1:0]     limit_q;
	logic [ADDR_W-1:0]     top_q;
	logic [CNT_W-1:0]      count_q;
	logic [MAX_BLOCKS-1:0] is_free_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic                  pend_s1;
	logic                  found_q;
	logic                  out_valid_q;

	// payload
	logic              type_q;
	logic [ADDR_W-1:0] size_q;
	logic [ADDR_W-1:0] faddr_q;
	logic [IDX_W-1:0]  idx_s1;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [ADDR_W-1:0] hit_start_q;
	logic [ADDR_W-1:0] out_addr_q;
	status_t           out_status_q;

	logic [ENTRY_W-1:0] rdata;
	logic [ADDR_W-1:0]  rd_start;
	logic [ADDR_W-1:0]  rd_bytes;
	logic               match;
	logic               scanning;
	logic               issue;
	logic [TOP_W-1:0]   new_top;
	logic               hit_last;

	status_t           res_status;
	logic [ADDR_W-1:0] res_addr;
	logic              do_use;
	logic              do_mark;
	logic              do_rel;
	logic              do_ext;

	ffha_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (cmd.commit && do_ext),
		.waddr(count_q[IDX_W-1:0]),
		.wdata({top_q, size_q}),
		.re   (issue),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	assign rd_start = rdata[ENTRY_W-1:ADDR_W];
	assign rd_bytes = rdata[ADDR_W-1:0];

	assign match = (type_q == REQ_ALLOC) ? (is_free_q[idx_s1] && (rd_bytes >= size_q))
	                                     : ((rd_start + HDR) == faddr_q);

	assign scanning = cmd.scan && !found_q;
	assign issue    = scanning && !(pend_s1 && match) && (rd_idx_q < count_q);

	assign new_top  = TOP_W'(top_q) + TOP_W'(HEADER_BYTES) + TOP_W'(size_q);
	assign hit_last = (CNT_W'(hit_idx_q) + CNT_W'(1)) == count_q;

	assign sts.trivial   = (type_q == REQ_ALLOC) ? (size_q == '0) : (faddr_q == '0);
	assign sts.scan_done = found_q || ((rd_idx_q == count_q) && !pend_s1);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		res_status = ST_UNKNOWN;
		res_addr   = '0;
		do_use     = 1'b0;
		do_mark    = 1'b0;
		do_rel     = 1'b0;
		do_ext     = 1'b0;
		if (type_q == REQ_ALLOC) begin
			if (size_q == '0) begin
				res_status = ST_ZERO;
			end else if (found_q) begin
				res_status = ST_REUSED;
				res_addr   = hit_start_q + HDR;
				do_use     = 1'b1;
			end else if (count_q == CNT_W'(MAX_BLOCKS)) begin
				res_status = ST_TABLE_FULL;
			end else if (new_top > TOP_W'(limit_q)) begin
				res_status = ST_HEAP_FULL;
			end else begin
				res_status = ST_EXTENDED;
				res_addr   = top_q + HDR;
				do_ext     = 1'b1;
			end
		end else if (faddr_q != '0 && found_q) begin
			if (hit_last) begin
				res_status = ST_RELEASED;
				do_rel     = 1'b1;
			end else begin
				res_status = ST_MARKED;
				do_mark    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			top_q       <= '0;
			count_q     <= '0;
			is_free_q   <= '0;
			rd_idx_q    <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.load) begin
				rd_idx_q <= '0;
				pend_s1  <= 1'b0;
				found_q  <= 1'b0;
			end else if (scanning) begin
				if (pend_s1 && match) begin
					found_q <= 1'b1;
					pend_s1 <= 1'b0;
				end else begin
					pend_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
				end
			end
			if (cmd.commit) begin
				if (do_use || do_rel) begin
					is_free_q[hit_idx_q] <= 1'b0;
				end
				if (do_mark) begin
					is_free_q[hit_idx_q] <= 1'b1;
				end
				if (do_rel) begin
					count_q <= count_q - CNT_W'(1);
					top_q   <= hit_start_q;
				end
				if (do_ext) begin
					is_free_q[count_q[IDX_W-1:0]] <= 1'b0;
					count_q <= count_q + CNT_W'(1);
					top_q   <= new_top[ADDR_W-1:0];
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q  <= req_type;
			size_q  <= req_size;
			faddr_q <= free_addr;
		end
		if (issue) begin
			idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (scanning && pend_s1 && match) begin
			hit_idx_q   <= idx_s1;
			hit_start_q <= rd_start;
		end
		if (cmd.commit) begin
			out_addr_q   <= res_addr;
			out_status_q <= res_status;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_addr = out_addr_q;
	assign status      = out_status_q;

endmodule

### src/first_fit_heap_allocator.sv
// first-fit heap allocator: keeps an address-ordered table of up to MAX_BLOCKS heap
// blocks (start, payload size, free flag) and a heap top. An allocate word walks the
// table for the first free block that is large enough and reuses it whole; failing
// that it appends a block of HEADER_BYTES plus the requested size at the top if the
// new top stays within heap_limit. A free word of the last block pops it and lowers
// the top, any other known block is only marked free. Every request word yields one
// result word. Timing: one request at a time; the walk through the block table memory
// reads one entry per cycle through its single read port. Zero-size allocates and null
// frees skip the walk. The result sits in an output register, so the next request is
// taken while the previous result waits. heap_limit resets to 1048576 and may only be
// written while the block is idle.
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	// heap_limit register write
	input  logic                        cfg_we,
	input  logic [ffha_pkg::ADDR_W-1:0] cfg_wdata,
	// request and result channels
	ffha_req_if.sink                    req,
	ffha_rsp_if.source                  rsp
);
	import ffha_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing: accept, walk table, commit and load result word
	ffha_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// block table, heap top, limit register and output register
	ffha_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req.req_type),
		.req_size   (req.req_size),
		.free_addr  (req.free_addr),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.result_addr(rsp.result_addr),
		.status     (rsp.status)
	);

	// a result is only loaded into a free or draining output slot
	`FFHA_ASSERT(a_commit_slot_free, cmd.commit, sts.out_free)
	// a commit always presents a result word next cycle
	`FFHA_ASSERT_NEXT(a_commit_shows_word, cmd.commit, rsp.valid)
	// one request in flight: ready drops right after an accept
	`FFHA_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready)

endmodule

### bench/tb_first_fit_heap_allocator.sv
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;
	import ffha_pkg::*;

	// one request word as the driver sees it
	typedef struct {
		logic              kind;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] addr;
	} req_word_t;

	// one result word: payload address and outcome
	typedef struct {
		logic [ADDR_W-1:0] addr;
		status_t           st;
	} heap_result_t;

	// directed row; typed rows carry their outcome, the rest lean on the predictor
	typedef struct {
		req_word_t    w;
		bit           typed;
		heap_result_t res;
	} heap_case_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [ADDR_W-1:0] cfg_wdata;

	ffha_req_if req_if ();
	ffha_rsp_if rsp_if ();

	first_fit_heap_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	// shadow of the block table, heap top and limit
	logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
	logic [ADDR_W-1:0] blk_bytes [MAX_BLOCKS];
	bit                blk_free [MAX_BLOCKS];
	int                blk_count;
	logic [ADDR_W-1:0] heap_top;
	logic [ADDR_W-1:0] heap_limit;

	heap_result_t pending_results[$];
	heap_case_t   directed_cases[$];

	int  errors;
	int  words_sent;
	int  limit_settings;
	int  status_seen [8];
	bit  req_quiet;
	bit  rsp_quiet;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// hang guard, several times the slowest legal run
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
			input logic [ADDR_W-1:0] want);
		// keep the log short once things go wrong
		if (errors < 100)
			$display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		errors++;
	endtask

	// apply one word to the shadow heap and return the outcome it must give
	function automatic heap_result_t heap_predict(input req_word_t w);
		heap_result_t           r;
		int                     i;
		bit                     hit;
		logic [ADDR_W+1:0]      new_top;
		r.addr = '0;
		r.st   = ST_UNKNOWN;
		hit    = 1'b0;
		if (w.kind == REQ_ALLOC) begin
			if (w.size == '0) begin
				r.st = ST_ZERO;
			end else begin
				// first fit, whole block reused, never split
				for (i = 0; i < blk_count && !hit; i++) begin
					if (blk_free[i] && blk_bytes[i] >= w.size) begin
						blk_free[i] = 1'b0;
						r.addr      = ADDR_W'(blk_start[i] + HEADER_BYTES);
						r.st        = ST_REUSED;
						hit         = 1'b1;
					end
				end
				if (!hit) begin
					new_top = (ADDR_W+2)'(heap_top) + (ADDR_W+2)'(HEADER_BYTES)
						+ (ADDR_W+2)'(w.size);
					// table check wins over the limit check
					if (blk_count >= MAX_BLOCKS) begin
						r.st = ST_TABLE_FULL;
					end else if (new_top > (ADDR_W+2)'(heap_limit)) begin
						r.st = ST_HEAP_FULL;
					end else begin
						blk_start[blk_count] = heap_top;
						blk_bytes[blk_count] = w.size;
						blk_free[blk_count]  = 1'b0;
						blk_count++;
						r.addr   = ADDR_W'(heap_top + HEADER_BYTES);
						r.st     = ST_EXTENDED;
						heap_top = ADDR_W'(new_top);
					end
				end
			end
		end else if (w.addr != '0) begin
			for (i = 0; i < blk_count && !hit; i++) begin
				if (ADDR_W'(blk_start[i] + HEADER_BYTES) == w.addr) begin
					hit = 1'b1;
					if (i == blk_count - 1) begin
						// last block pops and pulls the top down
						heap_top    = blk_start[i];
						blk_free[i] = 1'b0;
						blk_count--;
						r.st        = ST_RELEASED;
					end else begin
						blk_free[i] = 1'b1;
						r.st        = ST_MARKED;
					end
				end
			end
		end
		return r;
	endfunction

	// random word, mostly well-formed against the current shadow table
	function automatic req_word_t next_request();
		req_word_t w;
		int        pick;
		int        idx;
		pick   = $urandom_range(0, 99);
		w.size = ADDR_W'($urandom);
		w.addr = ADDR_W'($urandom);
		if (pick < 55) begin
			w.kind = REQ_ALLOC;
			pick   = $urandom_range(0, 99);
			if (pick < 3)
				w.size = '0;
			else if (pick < 68)
				w.size = ADDR_W'($urandom_range(1, 64));
			else if (pick < 88)
				w.size = ADDR_W'($urandom_range(1, 4096));
			else if (pick < 94 && blk_count > 0)
				// exact size of a live block, the fit boundary
				w.size = blk_bytes[$urandom_range(0, blk_count - 1)];
			// otherwise keep the full-width random size
		end else begin
			w.kind = REQ_FREE;
			if (pick < 80 && blk_count > 0) begin
				idx = ($urandom_range(0, 2) == 0) ? blk_count - 1
					: $urandom_range(0, blk_count - 1);
				w.addr = ADDR_W'(blk_start[idx] + HEADER_BYTES);
			end else if (pick < 88) begin
				w.addr = '0;
			end else if (pick < 94 && blk_count > 0) begin
				// one byte off a real payload address
				idx    = $urandom_range(0, blk_count - 1);
				w.addr = ADDR_W'(blk_start[idx] + HEADER_BYTES + 1);
			end
		end
		return w;
	endfunction

	// hand one word over, then predict it at the accepting edge
	task automatic issue_request(input req_word_t w, input bit typed,
			input heap_result_t typed_res);
		int           gap;
		heap_result_t r;
		if ($urandom_range(0, 39) == 0)
			req_quiet = !req_quiet;
		gap = req_quiet ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			req_if.valid     <= 1'b0;
			req_if.req_type  <= 1'($urandom);
			req_if.req_size  <= ADDR_W'($urandom);
			req_if.free_addr <= ADDR_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.req_type  <= w.kind;
		req_if.req_size  <= w.size;
		req_if.free_addr <= w.addr;
		do @(posedge clk); while (!req_if.ready);
		r = heap_predict(w);
		pending_results.push_back(typed ? typed_res : r);
		words_sent++;
	endtask

	// let every outstanding result come back so the block is idle
	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_heap_limit(input logic [ADDR_W-1:0] v);
		cfg_we     <= 1'b1;
		cfg_wdata  <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		heap_limit  = v;
		limit_settings++;
		@(posedge clk);
	endtask

	task automatic add_case(input logic kind, input logic [ADDR_W-1:0] size,
			input logic [ADDR_W-1:0] addr, input bit typed,
			input logic [ADDR_W-1:0] t_addr, input status_t t_st);
		heap_case_t c;
		c.w.kind   = kind;
		c.w.size   = size;
		c.w.addr   = addr;
		c.typed    = typed;
		c.res.addr = t_addr;
		c.res.st   = t_st;
		directed_cases.push_back(c);
	endtask

	task automatic run_random(input int n, input logic [ADDR_W-1:0] limit);
		heap_result_t none;
		none.addr = '0;
		none.st   = ST_UNKNOWN;
		drain_results();
		set_heap_limit(limit);
		repeat (n) issue_request(next_request(), 1'b0, none);
	endtask

	// result side: random back-pressure per word, quiet stretches now and then
	initial begin
		int gap;
		rsp_if.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rsp_quiet = !rsp_quiet;
			gap = rsp_quiet ? 0 : $urandom_range(0, 3);
			if (gap != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
		end
	end

	// compare every returned word with the oldest prediction
	always @(posedge clk) begin
		heap_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result word with nothing pending", rsp_if.result_addr, '0);
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.result_addr !== want.addr)
					report_mismatch("result_addr", rsp_if.result_addr, want.addr);
				if (status_t'(rsp_if.status) !== want.st)
					report_mismatch("status", ADDR_W'(rsp_if.status), ADDR_W'(want.st));
			end
			if (!$isunknown(rsp_if.status))
				status_seen[rsp_if.status]++;
		end
	end

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		req_if.valid     = 1'b0;
		req_if.req_type  = REQ_ALLOC;
		req_if.req_size  = '0;
		req_if.free_addr = '0;
		errors           = 0;
		words_sent       = 0;
		limit_settings   = 0;
		req_quiet        = 1'b0;
		rsp_quiet        = 1'b0;
		foreach (status_seen[i]) status_seen[i] = 0;

		// shadow state after reset
		blk_count  = 0;
		heap_top   = '0;
		heap_limit = LIMIT_RESET;
		foreach (blk_free[i]) begin
			blk_start[i] = '0;
			blk_bytes[i] = '0;
			blk_free[i]  = 1'b0;
		end

		// directed walk at the reset limit; zero expected fields are implied
		add_case(REQ_ALLOC, 24'd0,        24'd0,        1, 24'd0,  ST_ZERO);
		add_case(REQ_FREE,  24'd0,        24'd0,        1, 24'd0,  ST_UNKNOWN);
		// free on an empty table
		add_case(REQ_FREE,  24'd0,        24'd16,       1, 24'd0,  ST_UNKNOWN);
		add_case(REQ_ALLOC, 24'hFFFFFF,   24'd0,        1, 24'd0,  ST_HEAP_FULL);
		// first block lands right after its header
		add_case(REQ_ALLOC, 24'd1,        24'd0,        1, 24'd16, ST_EXTENDED);
		add_case(REQ_ALLOC, 24'hFFFFFF,   24'd0,        1, 24'd0,  ST_HEAP_FULL);
		add_case(REQ_ALLOC, 24'd100,      24'd0,        0, 24'd0,  ST_UNKNOWN);
		add_case(REQ_ALLOC, 24'd8,        24'd0,        0, 24'd0,  ST_UNKNOWN);
		// first block marked free, then freed a second time
		add_case(REQ_FREE,  24'd0,        24'd16,       1, 24'd0,  ST_MARKED);
		add_case(REQ_FREE,  24'd0,        24'd16,       1, 24'd0,  ST_MARKED);
		// free block too small, so this one extends
		add_case(REQ_ALLOC, 24'd2,        24'd0,        0, 24'd0,  ST_UNKNOWN);
		add_case(REQ_ALLOC, 24'd1,        24'd0,        1, 24'd16, ST_REUSED);
		add_case(REQ_FREE,  24'd0,        24'd33,       1, 24'd0,  ST_MARKED);
		// exact-size reuse
		add_case(REQ_ALLOC, 24'd100,      24'd0,        1, 24'd33, ST_REUSED);
		add_case(REQ_FREE,  24'd0,        24'd34,       1, 24'd0,  ST_UNKNOWN);
		add_case(REQ_FREE,  24'hFFFFFF,   24'hFFFFFF,   1, 24'd0,  ST_UNKNOWN);
		// top lands exactly on the limit, then nothing more fits
		add_case(REQ_ALLOC, 24'd1048385,  24'hFFFFFF,   0, 24'd0,  ST_UNKNOWN);
		add_case(REQ_ALLOC, 24'd1,        24'd0,        1, 24'd0,  ST_HEAP_FULL);
		// unwind the table from the top
		add_case(REQ_FREE,  24'd0,        24'd191,      1, 24'd0,  ST_RELEASED);
		add_case(REQ_FREE,  24'd0,        24'd173,      1, 24'd0,  ST_RELEASED);
		add_case(REQ_FREE,  24'd0,        24'd149,      1, 24'd0,  ST_RELEASED);
		add_case(REQ_FREE,  24'd0,        24'd33,       1, 24'd0,  ST_RELEASED);
		add_case(REQ_FREE,  24'd0,        24'd16,       1, 24'd0,  ST_RELEASED);
		add_case(REQ_FREE,  24'd0,        24'd16,       1, 24'd0,  ST_UNKNOWN);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_cases[i])
			issue_request(directed_cases[i].w, directed_cases[i].typed, directed_cases[i].res);

		// widest limit: the table fills up and table-full shows
		run_random(260, 24'hFFFFFF);
		// limit under the top: no block can be appended, only reuse succeeds
		run_random(80, 24'd0);
		// a little headroom above the current top, heap-full is common
		run_random(200, ADDR_W'((heap_top > 24'hFFFE00) ? 24'hFFFFFF
			: heap_top + ADDR_W'($urandom_range(0, 400))));
		run_random(210, LIMIT_RESET);

		drain_results();
		repeat (MAX_BLOCKS + 8) @(posedge clk);

		$display("sent %0d words over %0d limit settings; reused %0d, extended %0d, zero %0d",
			words_sent, limit_settings, status_seen[ST_REUSED], status_seen[ST_EXTENDED],
			status_seen[ST_ZERO]);
		$display("heap full %0d, table full %0d, marked %0d, released %0d, null/unknown %0d",
			status_seen[ST_HEAP_FULL], status_seen[ST_TABLE_FULL], status_seen[ST_MARKED],
			status_seen[ST_RELEASED], status_seen[ST_UNKNOWN]);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
